/* hw/rtl/lr_pkg.sv */
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// Coordinate widths, the request and pixel beat structs, the setup record that
// goes from the front end to the stepper, and the stepper state codes.
// ----------------------------------------------------------------------------
package lr_pkg;

    // Grid coordinate width and the widths that follow from it
    localparam int COORD_BITS     = 6;
    localparam int Y_BITS         = COORD_BITS + 1;
    localparam int DEC_BITS       = COORD_BITS + 3;
    localparam int STEP_BITS      = COORD_BITS + 2;
    localparam int SUM_BITS       = DEC_BITS + 1;

    // Setup queue between front end and stepper
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Request beat
    typedef struct packed {
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } line_req_t;

    // Result beat
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [Y_BITS-1:0]     pixel_y;
        logic                  last_pixel;
    } pixel_t;

    // Prepared line: first pixel, end x and the decision terms
    typedef struct packed {
        logic [COORD_BITS-1:0]       first_x;
        logic [Y_BITS-1:0]           first_y;
        logic [COORD_BITS-1:0]       stop_x;
        logic signed [DEC_BITS-1:0]  decision;
        logic [STEP_BITS-1:0]        step_even;
        logic signed [STEP_BITS-1:0] step_diag;
    } line_setup_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Stepper states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } step_state_t;

endpackage

/* hw/rtl/line_rasterizer.sv */
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line stepper, top level
// A front end sets up each line request, a two-entry queue holds prepared
// lines, and the stepper emits the pixels of the line one per cycle.
//
//   channel   handshake              payload      direction
//   request   start, busy            req          in
//   pixel     result_valid (strobe)  result       out
//
// A line of |dx|+1 pixels (up to 64) keeps the stepper busy, one pixel per
// cycle; lines held in the queue follow with no gap.
// When the stepper is free, the first pixel of a line follows its request beat
// through the setup register, the queue and the stepper load.
// busy is high while the setup register is full and the queue has no room.
// Reset clears all control state and the stepper registers.
// Results cannot be held off; each pixel beat lasts one cycle.
// ----------------------------------------------------------------------------
module line_rasterizer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lr_pkg::line_req_t req,
    output logic              result_valid,
    output lr_pkg::pixel_t    result
);

    lr_pkg::queue_status_t q_status;
    lr_pkg::line_setup_t   front_setup;
    lr_pkg::line_setup_t   queue_head;
    logic                  push;
    logic                  pop;

    // Request intake and setup
    lr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .q_status (q_status),
        .push     (push),
        .setup    (front_setup)
    );

    // Prepared line queue
    lr_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_setup),
        .pop     (pop),
        .rd_data (queue_head),
        .status  (q_status)
    );

    // Pixel stepper
    lr_stepper u_stepper
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .setup        (queue_head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // Within a line x moves up by exactly one per beat
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_pixel |=>
            result_valid && (result.pixel_x == $past(result.pixel_x) + 1'b1))
        else $error("pixel x did not advance by one within a line");

    // Within a line y holds or moves up by one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_pixel |=>
            (result.pixel_y == $past(result.pixel_y)) ||
            (result.pixel_y == $past(result.pixel_y) + 1'b1))
        else $error("pixel y stepped by more than one");

    // Queue never reports full and empty together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // No push into a full queue and no pop from an empty one
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full) && !(pop && q_status.empty))
        else $error("queue overrun or underrun");

endmodule

/* hw/rtl/lr_front.sv */
// ----------------------------------------------------------------------------
// lr_front: request intake and line setup
// Takes a request beat, orders the endpoints by x, works out dx, dy and the
// initial decision terms, and holds the setup record until the queue has room.
// ----------------------------------------------------------------------------
module lr_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lr_pkg::line_req_t     req,
    output logic                  busy,
    input  lr_pkg::queue_status_t q_status,
    output logic                  push,
    output lr_pkg::line_setup_t   setup
);

    logic                        valid_reg;
    logic                        valid_next;
    lr_pkg::line_setup_t         setup_reg;
    lr_pkg::line_setup_t         setup_next;
    logic                        accept;
    logic                        swap;
    logic [lr_pkg::COORD_BITS-1:0] dx;
    logic [lr_pkg::COORD_BITS-1:0] dy;

    // Holding register is free, or drains into the queue this cycle
    assign busy   = valid_reg && q_status.full;
    assign accept = start && !busy;
    assign push   = valid_reg && !q_status.full;
    assign setup  = setup_reg;

    // Endpoint ordering and line terms
    always_comb
    begin
        swap = req.start_x > req.end_x;
        dx   = swap ? (req.start_x - req.end_x) : (req.end_x - req.start_x);
        dy   = (req.end_y > req.start_y) ? (req.end_y - req.start_y)
                                         : (req.start_y - req.end_y);

        setup_next.first_x  = swap ? req.end_x : req.start_x;
        setup_next.first_y  = {1'b0, (swap ? req.end_y : req.start_y)};
        setup_next.stop_x   = swap ? req.start_x : req.end_x;
        // 2dy - dx
        setup_next.decision = $signed({2'b00, dy, 1'b0}) - $signed({3'b000, dx});
        // 2dy and 2(dy - dx)
        setup_next.step_even = {1'b0, dy, 1'b0};
        setup_next.step_diag = $signed({1'b0, dy, 1'b0}) - $signed({1'b0, dx, 1'b0});
    end

    // Holding register valid flag
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Setup payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            setup_reg <= setup_next;
        end
    end

endmodule

/* hw/rtl/lr_queue.sv */
// ----------------------------------------------------------------------------
// lr_queue: short setup queue
// Small register FIFO of prepared lines between front end and stepper, so that
// a new request is set up while the current line is still being stepped.
// ----------------------------------------------------------------------------
module lr_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lr_pkg::line_setup_t   wr_data,
    input  logic                  pop,
    output lr_pkg::line_setup_t   rd_data,
    output lr_pkg::queue_status_t status
);

    lr_pkg::line_setup_t                 entry_reg [lr_pkg::QUEUE_DEPTH];
    logic [lr_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_reg;
    logic [lr_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_next;
    logic [lr_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_reg;
    logic [lr_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_next;
    logic [lr_pkg::QUEUE_CNT_BITS-1:0]   count_reg;
    logic [lr_pkg::QUEUE_CNT_BITS-1:0]   count_next;

    assign status.full  = count_reg == lr_pkg::QUEUE_CNT_BITS'(lr_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign rd_data      = entry_reg[rd_ptr_reg];

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == lr_pkg::QUEUE_PTR_BITS'(lr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lr_pkg::QUEUE_PTR_BITS'(lr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hw/rtl/lr_stepper.sv */
// ----------------------------------------------------------------------------
// lr_stepper: Bresenham stepper
// Loads a prepared line from the queue and emits one pixel beat per cycle,
// moving x by one and y by the sign of the saturating decision term.
// ----------------------------------------------------------------------------
module lr_stepper
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lr_pkg::queue_status_t q_status,
    input  lr_pkg::line_setup_t   setup,
    output logic                  pop,
    output logic                  result_valid,
    output lr_pkg::pixel_t        result
);

    lr_pkg::step_state_t                 state_reg;
    lr_pkg::step_state_t                 state_next;
    logic [lr_pkg::COORD_BITS-1:0]       cur_x_reg;
    logic [lr_pkg::COORD_BITS-1:0]       cur_x_next;
    logic [lr_pkg::Y_BITS-1:0]           cur_y_reg;
    logic [lr_pkg::Y_BITS-1:0]           cur_y_next;
    logic [lr_pkg::COORD_BITS-1:0]       stop_x_reg;
    logic [lr_pkg::COORD_BITS-1:0]       stop_x_next;
    logic signed [lr_pkg::DEC_BITS-1:0]  decision_reg;
    logic signed [lr_pkg::DEC_BITS-1:0]  decision_next;
    logic [lr_pkg::STEP_BITS-1:0]        step_even_reg;
    logic [lr_pkg::STEP_BITS-1:0]        step_even_next;
    logic signed [lr_pkg::STEP_BITS-1:0] step_diag_reg;
    logic signed [lr_pkg::STEP_BITS-1:0] step_diag_next;
    logic                                last;
    logic signed [lr_pkg::SUM_BITS-1:0]  addend;
    logic signed [lr_pkg::SUM_BITS-1:0]  sum;
    logic signed [lr_pkg::DEC_BITS-1:0]  sum_sat;

    // Current pixel goes straight out of the registers
    assign last                = cur_x_reg == stop_x_reg;
    assign result_valid        = state_reg == lr_pkg::ST_RUN;
    assign result.pixel_x      = cur_x_reg;
    assign result.pixel_y      = cur_y_reg;
    assign result.last_pixel   = last;

    // Decision update with saturation to the signed range
    always_comb
    begin
        if (decision_reg[lr_pkg::DEC_BITS-1])
        begin
            addend = $signed({{(lr_pkg::SUM_BITS - lr_pkg::STEP_BITS){1'b0}}, step_even_reg});
        end
        else
        begin
            addend = lr_pkg::SUM_BITS'(step_diag_reg);
        end
        sum = lr_pkg::SUM_BITS'(decision_reg) + addend;
        if (sum[lr_pkg::SUM_BITS-1] != sum[lr_pkg::SUM_BITS-2])
        begin
            sum_sat = sum[lr_pkg::SUM_BITS-1]
                    ? {1'b1, {(lr_pkg::DEC_BITS-1){1'b0}}}
                    : {1'b0, {(lr_pkg::DEC_BITS-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[lr_pkg::DEC_BITS-1:0];
        end
    end

    // Sequencer: load a line, step it, load the next one without a gap
    always_comb
    begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        stop_x_next    = stop_x_reg;
        decision_next  = decision_reg;
        step_even_next = step_even_reg;
        step_diag_next = step_diag_reg;
        pop            = 1'b0;
        case (state_reg)
            lr_pkg::ST_IDLE:
            begin
                pop = !q_status.empty;
            end
            lr_pkg::ST_RUN:
            begin
                if (last)
                begin
                    pop = !q_status.empty;
                    if (q_status.empty)
                    begin
                        state_next = lr_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cur_x_next    = cur_x_reg + 1'b1;
                    decision_next = sum_sat;
                    if (!decision_reg[lr_pkg::DEC_BITS-1])
                    begin
                        cur_y_next = cur_y_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = lr_pkg::ST_IDLE;
            end
        endcase
        if (pop)
        begin
            state_next     = lr_pkg::ST_RUN;
            cur_x_next     = setup.first_x;
            cur_y_next     = setup.first_y;
            stop_x_next    = setup.stop_x;
            decision_next  = setup.decision;
            step_even_next = setup.step_even;
            step_diag_next = setup.step_diag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lr_pkg::ST_IDLE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            stop_x_reg    <= '0;
            decision_reg  <= '0;
            step_even_reg <= '0;
            step_diag_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            stop_x_reg    <= stop_x_next;
            decision_reg  <= decision_next;
            step_even_reg <= step_even_next;
            step_diag_reg <= step_diag_next;
        end
    end

endmodule
